@@ rtl/core/m3i_pkg.sv @@
package m3i_pkg;

   // element format
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int SCALE_SH  = 2 * FRAC_BITS;

   // internal widths
   localparam int PROD_W = 2 * ELEM_W;     // signed product of two elements
   localparam int COF_W  = PROD_W + 1;     // signed cofactor
   localparam int MAG_W  = PROD_W;         // cofactor magnitude
   localparam int TERM_W = 3 * ELEM_W;     // determinant term / magnitude
   localparam int DET_W  = TERM_W + 1;     // signed determinant term
   localparam int SUM_W  = DET_W + 2;      // signed determinant sum
   localparam int REM_W  = TERM_W + 1;     // divider partial remainder
   localparam int SAT_W  = TERM_W + 1;     // magnitude seen by saturation

   // divider: quotient fraction bits plus one round bit
   localparam int DIV_STEPS = SCALE_SH + 1;
   localparam int QUO_W     = SCALE_SH + 1;

   // front-to-back queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [SAT_W-1:0] DET_HALF = SAT_W'(1) << (SCALE_SH - 1);

   // cofactor k = m[a]*m[b] - m[c]*m[d], row-major order of the inverse
   localparam int COF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [8:0][ELEM_W-1:0] mat_type;

   // queue entry: matrix plus first-row magnitudes and signs
   typedef struct packed {
      mat_type                m;
      logic [2:0][ELEM_W-1:0] row_mag;
      logic [2:0]             row_neg;
   } fq_type;

   typedef struct packed {
      logic   valid;
      fq_type entry;
   } qhead_type;

   typedef struct packed {
      logic [SAT_W-1:0] mag;
      logic             neg;
      logic             zero;
   } det_dly_type;

   // sign and saturate a magnitude to the element range
   function automatic elem_type sat_elem(input logic [SAT_W-1:0] mag, input logic neg);
      logic [SAT_W-1:0] lim;
      logic [SAT_W-1:0] neg_mag;
      elem_type         res;
      lim     = SAT_W'(1) << (ELEM_W - 1);
      neg_mag = SAT_W'(0) - mag;
      if (mag >= lim) begin
         res = neg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (neg) begin
         res = neg_mag[ELEM_W-1:0];
      end else begin
         res = mag[ELEM_W-1:0];
      end
      return res;
   endfunction

endpackage

@@ rtl/core/m3i_if.sv @@
interface m3i_req_if;
   logic                   valid;
   logic                   ready;
   logic [m3i_pkg::ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 output ready);
endinterface

interface m3i_rsp_if;
   logic                   valid;
   logic                   ready;
   logic [m3i_pkg::ELEM_W-1:0] inv00, inv01, inv02, inv10, inv11, inv12;
   logic [m3i_pkg::ELEM_W-1:0] inv20, inv21, inv22, det_value;
   logic                   singular;

   modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, det_value, singular, input ready);
   modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                 inv20, inv21, inv22, det_value, singular, output ready);
endinterface

@@ rtl/core/matrix3_inverse.sv @@
// Throughput: one matrix per cycle while the response side does not stall;
//   depth is set by the 33-step restoring division pipes (one quotient bit
//   per stage, nine pipes in parallel).
// Reset: synchronous, active high; clears valid bits and queue pointers.
module matrix3_inverse (
   input  logic       clock,
   input  logic       reset,
   m3i_req_if.sink    req_ch,
   m3i_rsp_if.source  rsp_ch
);

   logic               push_valid;
   logic               push_ready;
   m3i_pkg::fq_type    push_entry;
   m3i_pkg::qhead_type head;
   logic               head_pop;

   m3i_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   m3i_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (head_pop),
      .head       (head)
   );

   m3i_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ rtl/core/m3i_front.sv @@
module m3i_front (
   input  logic            clock,
   input  logic            reset,
   m3i_req_if.sink         req_ch,
   output logic            push_valid,
   output m3i_pkg::fq_type push_entry,
   input  logic            push_ready
);

   logic            fr_vld_ff;
   m3i_pkg::fq_type fr_ent_ff;
   m3i_pkg::fq_type ent_in;

   assign req_ch.ready = !fr_vld_ff || push_ready;
   assign push_valid   = fr_vld_ff;
   assign push_entry   = fr_ent_ff;

   // gather the beat and split out first-row sign and magnitude
   always_comb begin
      ent_in.m[0] = req_ch.m00;
      ent_in.m[1] = req_ch.m01;
      ent_in.m[2] = req_ch.m02;
      ent_in.m[3] = req_ch.m10;
      ent_in.m[4] = req_ch.m11;
      ent_in.m[5] = req_ch.m12;
      ent_in.m[6] = req_ch.m20;
      ent_in.m[7] = req_ch.m21;
      ent_in.m[8] = req_ch.m22;
      for (int j = 0; j < 3; j++) begin
         ent_in.row_neg[j] = ent_in.m[j][m3i_pkg::ELEM_W-1];
         ent_in.row_mag[j] = ent_in.row_neg[j] ? (~ent_in.m[j] + 1'b1) : ent_in.m[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         fr_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         fr_ent_ff <= ent_in;
      end
   end

endmodule

@@ rtl/core/m3i_queue.sv @@
module m3i_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  m3i_pkg::fq_type    push_entry,
   output logic               push_ready,
   input  logic               pop,
   output m3i_pkg::qhead_type head
);

   m3i_pkg::fq_type               slot_ff [m3i_pkg::QDEPTH];
   logic [m3i_pkg::QPTR_W-1:0]    wr_ff;
   logic [m3i_pkg::QPTR_W-1:0]    rd_ff;
   logic [m3i_pkg::QPTR_W:0]      cnt_ff;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready  = cnt_ff != (m3i_pkg::QPTR_W+1)'(m3i_pkg::QDEPTH);
   assign head.valid  = cnt_ff != '0;
   assign head.entry  = slot_ff[rd_ff];
   assign do_push     = push_valid && push_ready;
   assign do_pop      = pop && head.valid;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/core/m3i_div.sv @@
module m3i_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [m3i_pkg::MAG_W-1:0]     num_mag,
   input  logic                          num_neg,
   input  logic [m3i_pkg::TERM_W-1:0]    den_mag,
   input  logic                          den_neg,
   output m3i_pkg::elem_type             quo
);

   localparam int NS = m3i_pkg::DIV_STEPS;

   logic [m3i_pkg::TERM_W-1:0] rem_ff [NS+1];
   logic [m3i_pkg::TERM_W-1:0] den_ff [NS+1];
   logic [NS-1:0]              q_ff   [NS+1];
   logic                       ovf_ff [NS+1];
   logic                       neg_ff [NS+1];
   logic [m3i_pkg::QUO_W-1:0]  mag_ff;
   logic                       ovf_r_ff;
   logic                       neg_r_ff;

   // entry: quotient of 2^SCALE_SH or more saturates, else remainder starts below divisor
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= m3i_pkg::TERM_W'(num_mag);
         den_ff[0] <= den_mag;
         q_ff[0]   <= '0;
         ovf_ff[0] <= m3i_pkg::TERM_W'(num_mag) >= den_mag;
         neg_ff[0] <= num_neg ^ den_neg;
      end
   end

   // one restoring step per stage, last step yields the round bit
   for (genvar i = 1; i <= NS; i++) begin : g_step
      logic [m3i_pkg::REM_W-1:0] r2;
      logic                      ge;
      assign r2 = {rem_ff[i-1], 1'b0};
      assign ge = r2 >= {1'b0, den_ff[i-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? m3i_pkg::TERM_W'(r2 - {1'b0, den_ff[i-1]})
                            : r2[m3i_pkg::TERM_W-1:0];
            den_ff[i] <= den_ff[i-1];
            q_ff[i]   <= {q_ff[i-1][NS-2:0], ge};
            ovf_ff[i] <= ovf_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // round half away from zero
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= m3i_pkg::QUO_W'(q_ff[NS][NS-1:1]) + m3i_pkg::QUO_W'(q_ff[NS][0]);
         ovf_r_ff <= ovf_ff[NS];
         neg_r_ff <= neg_ff[NS];
      end
   end

   assign quo = m3i_pkg::sat_elem(ovf_r_ff ? '1 : m3i_pkg::SAT_W'(mag_ff), neg_r_ff);

endmodule

@@ rtl/core/m3i_back.sv @@
module m3i_back (
   input  logic               clock,
   input  logic               reset,
   input  m3i_pkg::qhead_type head,
   output logic               head_pop,
   m3i_rsp_if.source          rsp_ch
);

   localparam int NS  = m3i_pkg::DIV_STEPS;
   localparam int LAT = 9 + NS + 2;

   logic                                en;
   logic [LAT-1:0]                      vld_ff;
   logic signed [m3i_pkg::PROD_W-1:0]   pa_ff [9];
   logic signed [m3i_pkg::PROD_W-1:0]   pb_ff [9];
   logic [2:0][m3i_pkg::ELEM_W-1:0]     rmag_ff [3];
   logic [2:0]                          rneg_ff [3];
   logic signed [m3i_pkg::COF_W-1:0]    cof_ff [9];
   logic [m3i_pkg::MAG_W-1:0]           cmag_ff [7][9];
   logic [8:0]                          cneg_ff [7];
   logic [m3i_pkg::PROD_W-1:0]          plo_ff [3];
   logic [m3i_pkg::PROD_W-1:0]          phi_ff [3];
   logic [2:0]                          tneg_ff [2];
   logic [m3i_pkg::TERM_W-1:0]          term_ff [3];
   logic signed [m3i_pkg::DET_W-1:0]    sterm_ff [3];
   logic signed [m3i_pkg::SUM_W-1:0]    part_ff;
   logic signed [m3i_pkg::SUM_W-1:0]    s2_ff;
   logic signed [m3i_pkg::SUM_W-1:0]    det_ff;
   logic [m3i_pkg::TERM_W-1:0]          dmag_ff;
   logic                                dneg_ff;
   m3i_pkg::det_dly_type                dly_ff [NS+2];
   m3i_pkg::det_dly_type                fin;
   m3i_pkg::elem_type                   quo [9];
   m3i_pkg::elem_type                   inv_ff [9];
   m3i_pkg::elem_type                   detv_ff;
   logic                                sing_ff;
   logic                                rsp_vld_ff;

   // whole pipe moves when the output register is free or drained
   assign en       = !rsp_vld_ff || rsp_ch.ready;
   assign head_pop = en && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[LAT-2:0], head.valid};
         rsp_vld_ff <= vld_ff[LAT-1];
      end
   end

   // determinant and cofactor datapath
   always_ff @(posedge clock) begin
      if (en) begin
         // element products
         for (int k = 0; k < 9; k++) begin
            pa_ff[k] <= $signed(head.entry.m[m3i_pkg::COF_IDX[k][0]])
                      * $signed(head.entry.m[m3i_pkg::COF_IDX[k][1]]);
            pb_ff[k] <= $signed(head.entry.m[m3i_pkg::COF_IDX[k][2]])
                      * $signed(head.entry.m[m3i_pkg::COF_IDX[k][3]]);
         end
         rmag_ff[0] <= head.entry.row_mag;
         rneg_ff[0] <= head.entry.row_neg;
         for (int s = 1; s < 3; s++) begin
            rmag_ff[s] <= rmag_ff[s-1];
            rneg_ff[s] <= rneg_ff[s-1];
         end
         // cofactors
         for (int k = 0; k < 9; k++) begin
            cof_ff[k] <= m3i_pkg::COF_W'(pa_ff[k]) - m3i_pkg::COF_W'(pb_ff[k]);
         end
         // cofactor sign and magnitude, carried to the dividers
         for (int k = 0; k < 9; k++) begin
            cneg_ff[0][k] <= cof_ff[k][m3i_pkg::COF_W-1];
            cmag_ff[0][k] <= cof_ff[k][m3i_pkg::COF_W-1] ? m3i_pkg::MAG_W'(-cof_ff[k])
                                                         : m3i_pkg::MAG_W'(cof_ff[k]);
         end
         for (int s = 1; s < 7; s++) begin
            cmag_ff[s] <= cmag_ff[s-1];
            cneg_ff[s] <= cneg_ff[s-1];
         end
         // first row times its cofactor, split in two half products
         for (int j = 0; j < 3; j++) begin
            plo_ff[j] <= rmag_ff[2][j] * cmag_ff[0][3*j][m3i_pkg::ELEM_W-1:0];
            phi_ff[j] <= rmag_ff[2][j] * cmag_ff[0][3*j][m3i_pkg::MAG_W-1:m3i_pkg::ELEM_W];
            tneg_ff[0][j] <= rneg_ff[2][j] ^ cneg_ff[0][3*j];
         end
         tneg_ff[1] <= tneg_ff[0];
         for (int j = 0; j < 3; j++) begin
            term_ff[j] <= {phi_ff[j], {m3i_pkg::ELEM_W{1'b0}}}
                        + m3i_pkg::TERM_W'(plo_ff[j]);
            sterm_ff[j] <= tneg_ff[1][j] ? -$signed({1'b0, term_ff[j]})
                                         : $signed({1'b0, term_ff[j]});
         end
         // determinant sum
         part_ff <= m3i_pkg::SUM_W'(sterm_ff[0]) + m3i_pkg::SUM_W'(sterm_ff[1]);
         s2_ff   <= m3i_pkg::SUM_W'(sterm_ff[2]);
         det_ff  <= part_ff + s2_ff;
         dneg_ff <= det_ff[m3i_pkg::SUM_W-1];
         dmag_ff <= det_ff[m3i_pkg::SUM_W-1] ? m3i_pkg::TERM_W'(-det_ff)
                                             : m3i_pkg::TERM_W'(det_ff);
         // rounded determinant, delayed alongside the dividers
         dly_ff[0].mag  <= (m3i_pkg::SAT_W'(dmag_ff) + m3i_pkg::DET_HALF)
                           >> m3i_pkg::SCALE_SH;
         dly_ff[0].neg  <= dneg_ff;
         dly_ff[0].zero <= dmag_ff == '0;
         for (int s = 1; s < NS + 2; s++) begin
            dly_ff[s] <= dly_ff[s-1];
         end
      end
   end

   // one divider pipe per inverse element
   for (genvar k = 0; k < 9; k++) begin : g_div
      m3i_div u_div (
         .clock   (clock),
         .en      (en),
         .num_mag (cmag_ff[6][k]),
         .num_neg (cneg_ff[6][k]),
         .den_mag (dmag_ff),
         .den_neg (dneg_ff),
         .quo     (quo[k])
      );
   end

   assign fin = dly_ff[NS+1];

   // output register, singular matrix forces zeros
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            inv_ff[k] <= fin.zero ? '0 : quo[k];
         end
         detv_ff <= fin.zero ? '0 : m3i_pkg::sat_elem(fin.mag, fin.neg);
         sing_ff <= fin.zero;
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.inv00     = inv_ff[0];
   assign rsp_ch.inv01     = inv_ff[1];
   assign rsp_ch.inv02     = inv_ff[2];
   assign rsp_ch.inv10     = inv_ff[3];
   assign rsp_ch.inv11     = inv_ff[4];
   assign rsp_ch.inv12     = inv_ff[5];
   assign rsp_ch.inv20     = inv_ff[6];
   assign rsp_ch.inv21     = inv_ff[7];
   assign rsp_ch.inv22     = inv_ff[8];
   assign rsp_ch.det_value = detv_ff;
   assign rsp_ch.singular  = sing_ff;

endmodule

@@ rtl/core/m3i_chk.sv @@
module m3i_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_singular,
   input logic [m3i_pkg::ELEM_W-1:0]  rsp_det_value,
   input logic [m3i_pkg::ELEM_W-1:0]  rsp_inv00,
   input logic [m3i_pkg::ELEM_W-1:0]  rsp_inv22
);

   logic [7:0] pend_ff;

   // beats accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 8'(req_valid && req_ready) - 8'(rsp_valid && rsp_ready);
      end
   end

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("response without pending request");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_det_value == '0 && rsp_inv00 == '0
                                    && rsp_inv22 == '0)
      else $error("singular response with nonzero fields");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      pend_ff == '0 |-> req_ready)
      else $error("idle block not ready");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_det_value))
      else $error("stalled response changed");

endmodule

bind matrix3_inverse m3i_chk u_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_singular  (rsp_ch.singular),
   .rsp_det_value (rsp_ch.det_value),
   .rsp_inv00     (rsp_ch.inv00),
   .rsp_inv22     (rsp_ch.inv22)
);

@@ tb/tb_matrix3_inverse.sv @@
`timescale 1ns / 1ps

// one 3x3 input matrix, row-major
typedef logic [31:0] matrix9_type [9];

// one expected or observed inverse beat
typedef struct {
   logic [31:0] inv [9];
   logic [31:0] det_value;
   logic        singular;
} inverse_beat_type;

// ---------------------------------------------------------------------------
// Inverse scoreboard: predicts each accepted matrix, checks responses in order
// ---------------------------------------------------------------------------
class inverse_scoreboard;
   inverse_beat_type pending_inverses [$];
   int               mismatch_count;

   // signed quotient rounded to nearest (ties away from zero), saturated
   static function logic [31:0] round_div_sat(logic signed [129:0] num,
                                             logic signed [129:0] den);
      logic [129:0] num_mag;
      logic [129:0] den_mag;
      logic [129:0] quo;
      logic [129:0] rem;
      logic         neg;
      num_mag = num[129] ? 130'(-num) : 130'(num);
      den_mag = den[129] ? 130'(-den) : 130'(den);
      quo     = num_mag / den_mag;
      rem     = num_mag % den_mag;
      if ((rem << 1) >= den_mag) quo = quo + 1;
      neg = num[129] ^ den[129];
      if (quo == 0) return 32'h0;
      if (!neg) return (quo > 130'h7fff_ffff) ? 32'h7fff_ffff : quo[31:0];
      return (quo > 130'h8000_0000) ? 32'h8000_0000 : 32'(-quo[31:0]);
   endfunction

   // exact adjugate and determinant, then the scaled quotients
   static function inverse_beat_type predict_inverse(matrix9_type m);
      logic signed [129:0] e [9];
      logic signed [129:0] cof [9];
      logic signed [129:0] det;
      logic signed [129:0] scale;
      inverse_beat_type    res;
      scale = 130'sd1 <<< 32;
      for (int k = 0; k < 9; k++) e[k] = $signed(m[k]);
      for (int k = 0; k < 9; k++)
         cof[k] = e[m3i_pkg::COF_IDX[k][0]] * e[m3i_pkg::COF_IDX[k][1]]
                - e[m3i_pkg::COF_IDX[k][2]] * e[m3i_pkg::COF_IDX[k][3]];
      det = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
      if (det == 0) begin
         for (int k = 0; k < 9; k++) res.inv[k] = '0;
         res.det_value = '0;
         res.singular  = 1'b1;
      end else begin
         for (int k = 0; k < 9; k++) res.inv[k] = round_div_sat(cof[k] * scale, det);
         res.det_value = round_div_sat(det, scale);
         res.singular  = 1'b0;
      end
      return res;
   endfunction

   function void note_matrix(matrix9_type m);
      pending_inverses.push_back(predict_inverse(m));
   endfunction

   function void check_inverse(inverse_beat_type got);
      inverse_beat_type want;
      bit               bad;
      if (pending_inverses.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("ERROR: response beat with no matrix pending");
         return;
      end
      want = pending_inverses.pop_front();
      bad  = 0;
      for (int k = 0; k < 9; k++) begin
         if (got.inv[k] !== want.inv[k]) begin
            bad = 1;
            if (mismatch_count < 10)
               $display("ERROR: inv%0d%0d expected %h got %h", k / 3, k % 3,
                        want.inv[k], got.inv[k]);
         end
      end
      if (got.det_value !== want.det_value) begin
         bad = 1;
         if (mismatch_count < 10)
            $display("ERROR: det_value expected %h got %h", want.det_value, got.det_value);
      end
      if (got.singular !== want.singular) begin
         bad = 1;
         if (mismatch_count < 10)
            $display("ERROR: singular expected %b got %b", want.singular, got.singular);
      end
      if (bad) mismatch_count++;
   endfunction
endclass

module tb_matrix3_inverse;
   localparam int  ONE        = 32'h0001_0000;
   localparam int  RAND_BEATS = 1750;
   localparam longint CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   longint cycle_count;
   bit     no_idle;

   m3i_req_if req_ch ();
   m3i_rsp_if rsp_ch ();

   matrix3_inverse dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   inverse_scoreboard scoreboard = new();

   // 12 ns clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // gap length: mostly short, a few long, none inside a burst stretch
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // capture accepted request beats
   always @(posedge clock) begin
      matrix9_type m;
      if (!reset && req_ch.valid && req_ch.ready) begin
         m = '{req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10, req_ch.m11,
               req_ch.m12, req_ch.m20, req_ch.m21, req_ch.m22};
         scoreboard.note_matrix(m);
      end
   end

   // check accepted response beats
   always @(posedge clock) begin
      inverse_beat_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.inv = '{rsp_ch.inv00, rsp_ch.inv01, rsp_ch.inv02, rsp_ch.inv10,
                     rsp_ch.inv11, rsp_ch.inv12, rsp_ch.inv20, rsp_ch.inv21,
                     rsp_ch.inv22};
         got.det_value = rsp_ch.det_value;
         got.singular  = rsp_ch.singular;
         scoreboard.check_inverse(got);
      end
   end

   // response-side backpressure
   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      forever begin
         g = pick_gap();
         if (g > 0) begin
            @(negedge clock) rsp_ch.ready <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   // drive one matrix after an optional gap; returns once the beat is taken
   task automatic send_matrix(matrix9_type m);
      int g;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock) req_ch.valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.m00 <= m[0]; req_ch.m01 <= m[1]; req_ch.m02 <= m[2];
      req_ch.m10 <= m[3]; req_ch.m11 <= m[4]; req_ch.m12 <= m[5];
      req_ch.m20 <= m[6]; req_ch.m21 <= m[7]; req_ch.m22 <= m[8];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      send_matrix('{a, 0, 0, 0, b, 0, 0, 0, c});
   endtask

   // element of a chosen flavor
   function automatic logic [31:0] rand_elem(int flavor);
      case (flavor)
         0: return $urandom();
         1: return $urandom_range(0, 16 * ONE) - 8 * ONE;
         2: return $urandom_range(0, 2 * ONE) - ONE;
         3: return $urandom_range(0, 511) - 256;
         default: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               3: return ONE;
               4: return -ONE;
               default: return $urandom();
            endcase
         end
      endcase
   endfunction

   function automatic matrix9_type rand_matrix();
      matrix9_type m;
      int          flavor;
      int          shape;
      int          src;
      int          dst;
      flavor = $urandom_range(0, 4);
      for (int k = 0; k < 9; k++)
         m[k] = ($urandom_range(0, 9) == 0) ? rand_elem($urandom_range(0, 4))
                                            : rand_elem(flavor);
      shape = $urandom_range(0, 9);
      src   = $urandom_range(0, 2);
      dst   = (src + $urandom_range(1, 2)) % 3;
      // rank-deficient shapes: copied, scaled or zero row, negated copy of a column
      if (shape == 0) for (int c = 0; c < 3; c++) m[dst*3+c] = m[src*3+c];
      else if (shape == 1) for (int c = 0; c < 3; c++) m[dst*3+c] = m[src*3+c] << 1;
      else if (shape == 2) for (int c = 0; c < 3; c++) m[dst*3+c] = '0;
      else if (shape == 3) for (int r = 0; r < 3; r++) m[r*3+dst] = -m[r*3+src];
      return m;
   endfunction

   initial begin
      matrix9_type m;
      req_ch.valid = 1'b0;
      {req_ch.m00, req_ch.m01, req_ch.m02, req_ch.m10, req_ch.m11} = '0;
      {req_ch.m12, req_ch.m20, req_ch.m21, req_ch.m22} = '0;
      cycle_count = 0;
      no_idle     = 0;
      reset       = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: identity, negated identity, zero, extremes, near-singular
      send_diag(ONE, ONE, ONE);
      send_diag(-ONE, -ONE, -ONE);
      send_diag(2 * ONE, ONE / 2, 4 * ONE);
      send_matrix('{default: 32'h0});
      send_matrix('{default: ONE});
      send_matrix('{default: 32'h7fff_ffff});
      send_matrix('{default: 32'h8000_0000});
      send_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_diag(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_diag(1, 1, 1);                      // determinant rounds to zero
      send_diag(32'hffff_ffff, 1, 32'hffff_ffff);
      send_diag(ONE, ONE, 1);
      send_matrix('{32'h0, ONE, 32'h0, ONE, 32'h0, 32'h0, 32'h0, 32'h0, ONE});
      send_matrix('{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE});
      send_matrix('{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0});
      send_matrix('{32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'h0f0f_0f0f,
                    32'hf0f0_f0f0, 32'h1234_5678, 32'h8765_4321, 32'h0000_ffff,
                    32'hffff_0000});
      send_matrix('{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                    32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff,
                    32'h8000_0000});
      send_diag(ONE, 32'h0, ONE);

      // random stream, with one full drain and burst stretches
      for (int i = 0; i < RAND_BEATS; i++) begin
         if (i % 250 == 0) no_idle = ($urandom_range(0, 2) == 0);
         if (i == RAND_BEATS / 2) begin
            @(negedge clock) req_ch.valid <= 1'b0;
            while (scoreboard.pending_inverses.size() != 0) @(posedge clock);
         end
         m = rand_matrix();
         send_matrix(m);
      end
      @(negedge clock) req_ch.valid <= 1'b0;

      while (scoreboard.pending_inverses.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (scoreboard.mismatch_count == 0 && scoreboard.pending_inverses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/m3i_pkg.sv
rtl/core/m3i_if.sv
rtl/core/m3i_front.sv
rtl/core/m3i_queue.sv
rtl/core/m3i_div.sv
rtl/core/m3i_back.sv
rtl/core/matrix3_inverse.sv
rtl/core/m3i_chk.sv
tb/tb_matrix3_inverse.sv
